[sv/wrapped_error_persistence_monitor_macros.svh]
// Assertion macros shared by the tracking-error monitor RTL.
// Defining ASSERT_OFF removes every check; nothing else is needed.
`ifndef WRAPPED_ERROR_PERSISTENCE_MONITOR_MACROS_SVH
`define WRAPPED_ERROR_PERSISTENCE_MONITOR_MACROS_SVH
`ifndef ASSERT_OFF
// Plain property check, clocked and disabled while reset is low.
`define WEPM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Same-cycle implication check.
`define WEPM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define WEPM_ASSERT(lbl, clk, rst_n, prop, msg)
`define WEPM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[sv/wepm_pkg.sv]
// Package for the tracking-error monitor: default widths, register field
// widths and the configuration register map. No dependencies.
package wepm_pkg;

  // Default widths of the value and timestamp fields.
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int TIME_WIDTH_DEF  = 32;

  // Fixed widths of the configuration registers.
  localparam int RANGE_W    = 31;
  localparam int THR_W      = 31;
  localparam int LIMIT_W    = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  // Configuration register map.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WRAP_ENABLE       = 2'd0,
    REG_WRAP_RANGE        = 2'd1,
    REG_ERROR_THRESHOLD   = 2'd2,
    REG_EXCEED_TIME_LIMIT = 2'd3
  } cfg_reg_e;

endpackage

[sv/wepm_if.sv]
// Valid/ready channel interfaces of the tracking-error monitor: sample input,
// result output and configuration writes. Depends on wepm_pkg.

// Sample input channel.
interface wepm_in_if import wepm_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] command_value;
  logic signed [VALUE_WIDTH-1:0] feedback_value;
  logic        [TIME_WIDTH-1:0]  now_us;
  logic                          safety_active;
  logic                          sample_invalid;

  modport source (output valid, command_value, feedback_value, now_us,
                  safety_active, sample_invalid, input ready);
  modport sink (input valid, command_value, feedback_value, now_us,
                safety_active, sample_invalid, output ready);
endinterface

// Result output channel.
interface wepm_out_if import wepm_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          fault;
  logic signed [VALUE_WIDTH-1:0] error_out;
  logic                          over_threshold;

  modport source (output valid, fault, error_out, over_threshold, input ready);
  modport sink (input valid, fault, error_out, over_threshold, output ready);
endinterface

// Configuration write channel.
interface wepm_cfg_if import wepm_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/wrapped_error_persistence_monitor.sv]
// Top level of the tracking-error monitor with angle unwrap.
// Depends on wepm_pkg, the channel interfaces in wepm_if.sv and the
// assertion macros header.
//
// Usage: samples arrive as beats on in_i, results leave as beats on out_o,
// one result per sample, in order. Registers are written through cfg_i,
// which is always ready; write them only while the block is idle.
// A sample is taken only while the sequencer is idle; the difference, fold,
// unwrap, magnitude and elapsed-time sums share one adder. A sample without
// wrapping passes S_DIFF, S_SAT, S_MAG, S_TIME and S_RESULT. With wrapping
// active, S_DELTA follows S_DIFF, with S_ADJ when the unwrap step is taken;
// a safety or invalid sample goes from idle straight to S_RESULT.
// The first sample with wrapping active goes to S_FDIR instead; if it lies
// outside the half range it folds its error by a shift-and-subtract search
// over the range shifted down in S_FOLD, with the last range step in S_FLAST.
// The sequencer returns to idle, and can take the next sample, in the cycle
// after its result is loaded into the output register.
// The output register holds a result while the receiver stalls; a finished
// result waits in the sequencer until that register is free.
// Reset clears the configuration registers, the monitor state and the output valid.

`include "wrapped_error_persistence_monitor_macros.svh"

module wrapped_error_persistence_monitor import wepm_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  wepm_cfg_if.sink   cfg_i,
  wepm_in_if.sink    in_i,
  wepm_out_if.source out_o
);

  // Working widths: IW holds any unwrapped error, SW also the shifted range.
  localparam int IW         = ((VALUE_WIDTH > LIMIT_W) ? VALUE_WIDTH : LIMIT_W) + 2;
  localparam int SW         = IW + RANGE_W;
  localparam int ET_W       = (TIME_WIDTH > LIMIT_W) ? TIME_WIDTH : LIMIT_W;
  localparam int STEPS      = IW - 1;
  localparam int CW         = $clog2(STEPS);
  localparam int FOLD_SHIFT = IW - 2;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_DIFF   = 11'b000_0000_0010,
    S_FDIR   = 11'b000_0000_0100,
    S_FOLD   = 11'b000_0000_1000,
    S_FLAST  = 11'b000_0001_0000,
    S_DELTA  = 11'b000_0010_0000,
    S_ADJ    = 11'b000_0100_0000,
    S_SAT    = 11'b000_1000_0000,
    S_MAG    = 11'b001_0000_0000,
    S_TIME   = 11'b010_0000_0000,
    S_RESULT = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic               wrap_en_q, wrap_en_d;
  logic [RANGE_W-1:0] range_q, range_d;
  logic [THR_W-1:0]   thr_q, thr_d;
  logic [LIMIT_W-1:0] limit_q, limit_d;

  // Monitor state.
  logic                          seen_q, seen_d;
  logic signed [VALUE_WIDTH-1:0] prev_q, prev_d;
  logic                          exceeding_q, exceeding_d;
  logic [TIME_WIDTH-1:0]         start_q, start_d;

  // Working registers of the current sample.
  logic signed [VALUE_WIDTH-1:0] ref_q, ref_d;
  logic signed [VALUE_WIDTH-1:0] est_q, est_d;
  logic [TIME_WIDTH-1:0]         now_q, now_d;
  logic signed [IW-1:0]          acc_q, acc_d;
  logic signed [SW-1:0]          rsh_q, rsh_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic                          dir_sub_q, dir_sub_d;
  logic signed [VALUE_WIDTH-1:0] err_q, err_d;
  logic                          over_q, over_d;
  logic                          fault_q, fault_d;

  // Output register.
  logic                          out_valid_q, out_valid_d;
  logic                          out_fault_q, out_fault_d;
  logic signed [VALUE_WIDTH-1:0] out_err_q, out_err_d;
  logic                          out_over_q, out_over_d;

  // Shared adder and its operands.
  logic signed [SW-1:0] add_a, add_b, add_sum;
  logic                 add_sub;

  logic signed [SW-1:0] acc_w, halfw, nhalfw, mag_w, thr_w;
  logic signed [IW-1:0] vmax_w, vmin_w;
  logic [ET_W-1:0]      elapsed_w;
  logic                 wrapping, in_beat, out_load, fold_ok;

  assign in_beat  = in_i.valid && in_i.ready;
  assign wrapping = wrap_en_q && (range_q != '0);
  assign acc_w    = {{(SW-IW){acc_q[IW-1]}}, acc_q};
  assign halfw    = SW'(range_q[RANGE_W-1:1]);
  assign nhalfw   = -halfw;
  assign thr_w    = SW'(thr_q);
  assign vmax_w   = IW'({(VALUE_WIDTH-1){1'b1}});
  assign vmin_w   = ~vmax_w;
  assign fold_ok  = (acc_w <= halfw) && (acc_w >= nhalfw);

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign out_o.valid          = out_valid_q;
  assign out_o.fault          = out_fault_q;
  assign out_o.error_out      = out_err_q;
  assign out_o.over_threshold = out_over_q;

  // Operand selection for the shared adder, one use per sequencer state.
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_q)
      S_DIFF: begin
        add_a   = {{(SW-VALUE_WIDTH){ref_q[VALUE_WIDTH-1]}}, ref_q};
        add_b   = {{(SW-VALUE_WIDTH){est_q[VALUE_WIDTH-1]}}, est_q};
        add_sub = 1'b1;
      end
      S_FOLD: begin
        add_a   = acc_w;
        add_b   = rsh_q;
        add_sub = dir_sub_q;
      end
      S_FLAST, S_ADJ: begin
        add_a   = acc_w;
        add_b   = SW'(range_q);
        add_sub = dir_sub_q;
      end
      S_DELTA: begin
        add_a   = acc_w;
        add_b   = {{(SW-VALUE_WIDTH){prev_q[VALUE_WIDTH-1]}}, prev_q};
        add_sub = 1'b1;
      end
      S_MAG: begin
        add_b   = {{(SW-VALUE_WIDTH){err_q[VALUE_WIDTH-1]}}, err_q};
        add_sub = 1'b1;
      end
      S_TIME: begin
        add_a   = SW'(now_q);
        add_b   = SW'(start_q);
        add_sub = 1'b1;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  assign add_sum   = add_sub ? (add_a - add_b) : (add_a + add_b);
  assign mag_w     = err_q[VALUE_WIDTH-1] ? add_sum
                                          : {{(SW-VALUE_WIDTH){err_q[VALUE_WIDTH-1]}}, err_q};
  assign elapsed_w = ET_W'(add_sum[TIME_WIDTH-1:0]);
  assign out_load  = (state_q == S_RESULT) && (!out_valid_q || out_o.ready);

  // Configuration writes.
  always_comb begin
    wrap_en_d = wrap_en_q;
    range_d   = range_q;
    thr_d     = thr_q;
    limit_d   = limit_q;
    if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_WRAP_ENABLE:       wrap_en_d = cfg_i.data[0];
        REG_WRAP_RANGE:        range_d   = cfg_i.data[RANGE_W-1:0];
        REG_ERROR_THRESHOLD:   thr_d     = cfg_i.data[THR_W-1:0];
        REG_EXCEED_TIME_LIMIT: limit_d   = cfg_i.data[LIMIT_W-1:0];
        default:               wrap_en_d = wrap_en_q;
      endcase
    end
  end

  // Sequencer: difference, optional fold or unwrap, saturation, threshold
  // and elapsed-time test, then hand-over to the output register.
  always_comb begin
    state_d     = state_q;
    seen_d      = seen_q;
    prev_d      = prev_q;
    exceeding_d = exceeding_q;
    start_d     = start_q;
    ref_d       = ref_q;
    est_d       = est_q;
    now_d       = now_q;
    acc_d       = acc_q;
    rsh_d       = rsh_q;
    cnt_d       = cnt_q;
    dir_sub_d   = dir_sub_q;
    err_d       = err_q;
    over_d      = over_q;
    fault_d     = fault_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          ref_d = in_i.command_value;
          est_d = in_i.feedback_value;
          now_d = in_i.now_us;
          if (in_i.safety_active) begin
            // Safety mode returns the monitor to its reset state.
            seen_d      = 1'b0;
            prev_d      = '0;
            exceeding_d = 1'b0;
            start_d     = '0;
            err_d       = '0;
            over_d      = 1'b0;
            fault_d     = 1'b0;
            state_d     = S_RESULT;
          end else if (in_i.sample_invalid) begin
            err_d   = '0;
            over_d  = 1'b0;
            fault_d = 1'b1;
            state_d = S_RESULT;
          end else begin
            state_d = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        acc_d  = add_sum[IW-1:0];
        seen_d = 1'b1;
        if (wrapping && !seen_q) begin
          state_d = S_FDIR;
        end else if (wrapping) begin
          state_d = S_DELTA;
        end else begin
          state_d = S_SAT;
        end
      end
      S_FDIR: begin
        rsh_d = SW'(range_q) << FOLD_SHIFT;
        cnt_d = CW'(STEPS - 1);
        if (acc_w > halfw) begin
          dir_sub_d = 1'b1;
          state_d   = S_FOLD;
        end else if (acc_w < nhalfw) begin
          dir_sub_d = 1'b0;
          state_d   = S_FOLD;
        end else begin
          state_d = S_SAT;
        end
      end
      S_FOLD: begin
        // Take the shifted range step while the error stays outside the
        // half range; the last range step follows in S_FLAST.
        if (dir_sub_q ? (add_sum > halfw) : (add_sum < nhalfw)) begin
          acc_d = add_sum[IW-1:0];
        end
        rsh_d = rsh_q >>> 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_FLAST;
        end
      end
      S_FLAST: begin
        acc_d   = add_sum[IW-1:0];
        state_d = S_SAT;
      end
      S_DELTA: begin
        if (add_sum > halfw) begin
          dir_sub_d = 1'b1;
          state_d   = S_ADJ;
        end else if (add_sum < nhalfw) begin
          dir_sub_d = 1'b0;
          state_d   = S_ADJ;
        end else begin
          state_d = S_SAT;
        end
      end
      S_ADJ: begin
        acc_d   = add_sum[IW-1:0];
        state_d = S_SAT;
      end
      S_SAT: begin
        if (acc_q > vmax_w) begin
          err_d = vmax_w[VALUE_WIDTH-1:0];
        end else if (acc_q < vmin_w) begin
          err_d = vmin_w[VALUE_WIDTH-1:0];
        end else begin
          err_d = acc_q[VALUE_WIDTH-1:0];
        end
        prev_d  = err_d;
        state_d = S_MAG;
      end
      S_MAG: begin
        over_d = (mag_w > thr_w);
        if (mag_w > thr_w) begin
          if (!exceeding_q) begin
            exceeding_d = 1'b1;
            start_d     = now_q;
          end
        end else begin
          exceeding_d = 1'b0;
          start_d     = '0;
        end
        state_d = S_TIME;
      end
      S_TIME: begin
        fault_d = over_q && (elapsed_w >= ET_W'(limit_q));
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: loads a finished result, drops valid after its beat.
  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    out_fault_d = out_fault_q;
    out_err_d   = out_err_q;
    out_over_d  = out_over_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_fault_d = fault_q;
      out_err_d   = err_q;
      out_over_d  = over_q;
    end
  end

  // Control and monitor state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wrap_en_q   <= 1'b0;
      range_q     <= '0;
      thr_q       <= '0;
      limit_q     <= '0;
      seen_q      <= 1'b0;
      prev_q      <= '0;
      exceeding_q <= 1'b0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wrap_en_q   <= wrap_en_d;
      range_q     <= range_d;
      thr_q       <= thr_d;
      limit_q     <= limit_d;
      seen_q      <= seen_d;
      prev_q      <= prev_d;
      exceeding_q <= exceeding_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ref_q       <= ref_d;
    est_q       <= est_d;
    now_q       <= now_d;
    acc_q       <= acc_d;
    rsh_q       <= rsh_d;
    cnt_q       <= cnt_d;
    dir_sub_q   <= dir_sub_d;
    err_q       <= err_d;
    over_q      <= over_d;
    fault_q     <= fault_d;
    out_fault_q <= out_fault_d;
    out_err_q   <= out_err_d;
    out_over_q  <= out_over_d;
  end

  // A fault comes from an invalid sample (zero error) or a lasting overshoot.
  `WEPM_ASSERT_IMPL(a_fault_cause, clk_i, rst_ni, out_valid_q && out_fault_q, out_over_q || (out_err_q == '0), "fault without overshoot or invalid sample")
  // An overshoot needs a non-zero error.
  `WEPM_ASSERT_IMPL(a_over_nonzero, clk_i, rst_ni, out_valid_q && out_over_q, out_err_q != '0, "overshoot flagged with zero error")
  // The start timestamp is only held while the error is above threshold.
  `WEPM_ASSERT_IMPL(a_start_cleared, clk_i, rst_ni, !exceeding_q, start_q == '0, "start time kept while not exceeding")
  // A completed fold leaves the error inside plus or minus half the range.
  `WEPM_ASSERT_IMPL(a_fold_range, clk_i, rst_ni, (state_q == S_SAT) && ($past(state_q) == S_FLAST), fold_ok, "folded error outside half range")
  // An accepted sample always starts the sequencer.
  `WEPM_ASSERT(a_accept_busy, clk_i, rst_ni, in_beat |=> (state_q != S_IDLE), "sequencer idle after input beat")

endmodule

[dv/wrapped_error_persistence_monitor_tb.sv]
// Self-checking testbench for the tracking-error monitor: a directed opening, then
// random phases under varied register settings, each result checked against a local model.
// Depends on wepm_pkg, the channel interfaces in wepm_if.sv and the monitor RTL.
`timescale 1ns / 100ps

module wrapped_error_persistence_monitor_tb;
  import wepm_pkg::*;

  localparam int     VW            = VALUE_WIDTH_DEF;
  localparam int     TW            = TIME_WIDTH_DEF;
  localparam longint VAL_MAX       = 64'sd2147483647;
  localparam longint VAL_MIN       = -64'sd2147483648;
  localparam int     DEG           = 65536;
  localparam int     FULL_TURN_DEG = 360 * DEG;
  localparam int     FULL_TURN_RAD = 411775;
  localparam int     RANDOM_PHASES = 7;
  localparam int     PHASE_ITEMS   = 250;
  localparam int     DRAIN_CYCLES  = 60;
  localparam int     QUIET_LIMIT   = 3000;

  typedef struct packed {
    logic [VW-1:0] ref_v;
    logic [VW-1:0] est_v;
    logic [TW-1:0] now;
    logic          safety;
    logic          invalid;
  } sample_t;

  typedef struct packed {
    logic          fault;
    logic [VW-1:0] err;
    logic          over;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  wepm_cfg_if cfg_bus ();
  wepm_in_if  in_bus ();
  wepm_out_if out_bus ();

  wrapped_error_persistence_monitor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Register shadows, written as each configuration beat is taken.
  logic                wrap_en_q      = 1'b0;
  logic [RANGE_W-1:0]  wrap_range_q   = '0;
  logic [THR_W-1:0]    err_thr_q      = '0;
  logic [LIMIT_W-1:0]  exceed_limit_q = '0;

  // Tracking state of the model.
  logic                seen_first_q   = 1'b0;
  longint              last_err_q     = 0;
  logic                exceeding_q    = 1'b0;
  logic [TW-1:0]       exceed_start_q = '0;

  sample_t             sample_backlog[$];
  result_t             pending_results[$];
  logic                in_taken;
  logic                steady = 1'b0;
  int unsigned         feed_gap = 0;
  int unsigned         stall_left = 0;
  int                  quiet_cycles = 0;
  int                  error_count = 0;

  // Clock: 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Works out the result of one sample and advances the tracking state.
  function automatic result_t track_sample(sample_t s);
    result_t       res;
    longint        a, b, e, span, half, d, mag, thr;
    logic [TW-1:0] elapsed;
    res  = '0;
    span = wrap_range_q;
    half = span >>> 1;
    thr  = err_thr_q;
    if (s.safety) begin
      seen_first_q   = 1'b0;
      last_err_q     = 0;
      exceeding_q    = 1'b0;
      exceed_start_q = '0;
      return res;
    end
    if (s.invalid) begin
      res.fault = 1'b1;
      return res;
    end
    a = $signed(s.ref_v);
    b = $signed(s.est_v);
    e = a - b;
    if (!seen_first_q) begin
      seen_first_q = 1'b1;
      // The first error is normalised into plus or minus half a range.
      if (wrap_en_q && span != 0) begin
        if (e > half) begin
          d = e - half - 1;
          e = half + 1 + d % span - span;
        end else if (e < -half) begin
          d = -half - 1 - e;
          e = -half - 1 - d % span + span;
        end
      end
    end else if (wrap_en_q && span != 0) begin
      // Later errors move by at most one range step against the last one.
      if (e - last_err_q > half) begin
        e = e - span;
      end else if (e - last_err_q < -half) begin
        e = e + span;
      end
    end
    if (e > VAL_MAX) e = VAL_MAX;
    if (e < VAL_MIN) e = VAL_MIN;
    last_err_q = e;
    mag = (e < 0) ? -e : e;
    res.err = e[VW-1:0];
    res.over = (mag > thr);
    if (res.over) begin
      if (!exceeding_q) begin
        exceeding_q    = 1'b1;
        exceed_start_q = s.now;
      end
      // Elapsed time wraps with the timestamp.
      elapsed = s.now - exceed_start_q;
      res.fault = (elapsed >= exceed_limit_q);
    end else begin
      exceeding_q    = 1'b0;
      exceed_start_q = '0;
    end
    return res;
  endfunction

  // Pause length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_pause();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic void check_field(string what, logic [VW-1:0] want, logic [VW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      error_count++;
    end
  endfunction

  function automatic void add_sample(logic [VW-1:0] ref_v, logic [VW-1:0] est_v,
                                     logic [TW-1:0] now, logic safety, logic invalid);
    sample_t s;
    s.ref_v   = ref_v;
    s.est_v   = est_v;
    s.now     = now;
    s.safety  = safety;
    s.invalid = invalid;
    sample_backlog.push_back(s);
  endfunction

  // One register write beat; the shadow follows once the beat is taken.
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    case (idx)
      REG_WRAP_ENABLE:       wrap_en_q      = value[0];
      REG_WRAP_RANGE:        wrap_range_q   = value[RANGE_W-1:0];
      REG_ERROR_THRESHOLD:   err_thr_q      = value[THR_W-1:0];
      REG_EXCEED_TIME_LIMIT: exceed_limit_q = value[LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic apply_settings(logic en, logic [RANGE_W-1:0] span,
                                logic [THR_W-1:0] thr, logic [LIMIT_W-1:0] lim);
    write_reg(REG_WRAP_ENABLE, {{(CFG_DATA_W-1){1'b0}}, en});
    write_reg(REG_WRAP_RANGE, {{(CFG_DATA_W-RANGE_W){1'b0}}, span});
    write_reg(REG_ERROR_THRESHOLD, {{(CFG_DATA_W-THR_W){1'b0}}, thr});
    write_reg(REG_EXCEED_TIME_LIMIT, lim);
  endtask

  // Returns once every sample has been taken and every result has come back.
  task automatic wait_idle();
    @(posedge clk_i);
    while (sample_backlog.size() != 0 || in_bus.valid || pending_results.size() != 0)
      @(posedge clk_i);
  endtask

  // Sample driver: holds each beat until taken, then pauses at random.
  always @(negedge clk_i) begin : feed
    sample_t s;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_taken) begin
      if (feed_gap != 0) begin
        in_bus.valid <= 1'b0;
        feed_gap--;
      end else if (sample_backlog.size() != 0) begin
        s = sample_backlog.pop_front();
        in_bus.command_value  <= s.ref_v;
        in_bus.feedback_value <= s.est_v;
        in_bus.now_us         <= s.now;
        in_bus.safety_active  <= s.safety;
        in_bus.sample_invalid <= s.invalid;
        in_bus.valid          <= 1'b1;
        feed_gap = pick_pause();
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Result receiver: stalls of random length between ready stretches.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_bus.ready <= 1'b0;
      stall_left--;
    end else begin
      out_bus.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_pause();
    end
  end

  // Monitor: checks each result beat and predicts each sample beat.
  always @(posedge clk_i) begin : watch
    sample_t s;
    result_t want;
    logic    in_beat, out_beat, cfg_beat;
    if (!rst_ni) begin
      in_taken     <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_beat  = in_bus.valid && in_bus.ready;
      out_beat = out_bus.valid && out_bus.ready;
      cfg_beat = cfg_bus.valid && cfg_bus.ready;
      if (out_beat) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual fault=%0b error_out=%0h over=%0b",
                   $time, out_bus.fault, out_bus.error_out, out_bus.over_threshold);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("fault", VW'(want.fault), VW'(out_bus.fault));
          check_field("error_out", want.err, out_bus.error_out);
          check_field("over_threshold", VW'(want.over), VW'(out_bus.over_threshold));
        end
      end
      if (in_beat) begin
        s.ref_v   = in_bus.command_value;
        s.est_v   = in_bus.feedback_value;
        s.now     = in_bus.now_us;
        s.safety  = in_bus.safety_active;
        s.invalid = in_bus.sample_invalid;
        pending_results.push_back(track_sample(s));
      end
      in_taken     <= in_beat;
      quiet_cycles <= (in_beat || out_beat || cfg_beat) ? 0 : quiet_cycles + 1;
    end
  end

  // Watchdog on a channel that has gone quiet.
  always @(posedge clk_i) begin
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    sample_t             s;
    longint              mag;
    int unsigned         roll;
    logic [TW-1:0]       clock_cursor;
    bit                  hold_over;
    logic                en_v;
    logic [RANGE_W-1:0]  span_v;
    logic [THR_W-1:0]    thr_v;
    logic [LIMIT_W-1:0]  lim_v;

    rst_ni                = 1'b0;
    in_bus.valid          = 1'b0;
    in_bus.command_value  = '0;
    in_bus.feedback_value = '0;
    in_bus.now_us         = '0;
    in_bus.safety_active  = 1'b0;
    in_bus.sample_invalid = 1'b0;
    out_bus.ready         = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = REG_WRAP_ENABLE;
    cfg_bus.data          = '0;
    clock_cursor          = '0;
    hold_over             = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Degree wrap: safety clear, first-sample folds both ways, unwrap steps,
    // invalid sample, persistence across a timestamp wrap.
    apply_settings(1'b1, RANGE_W'(FULL_TURN_DEG), THR_W'(10 * DEG), 100);
    add_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
    add_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0, 1'b0);
    add_sample(179 * DEG, -179 * DEG, 32'd10, 1'b0, 1'b0);
    add_sample(-179 * DEG, 179 * DEG, 32'd20, 1'b0, 1'b0);
    add_sample(32'h0, 32'h0, 32'd30, 1'b0, 1'b1);
    add_sample(20 * DEG, 32'h0, 32'hFFFF_FFF0, 1'b0, 1'b0);
    add_sample(25 * DEG, 32'h0, 32'h40, 1'b0, 1'b0);
    add_sample(25 * DEG, 32'h0, 32'h60, 1'b0, 1'b0);
    add_sample(-30 * DEG, 32'h0, 32'h70, 1'b0, 1'b0);
    add_sample(32'h0, 32'h0, 32'h80, 1'b0, 1'b0);
    add_sample(32'h0, 32'h0, 32'h90, 1'b1, 1'b0);
    add_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'd100, 1'b0, 1'b0);
    add_sample(32'h0, 32'h0, 32'd110, 1'b0, 1'b0);
    wait_idle();

    // No wrapping, zero threshold and limit: saturation and instant faults.
    apply_settings(1'b0, '0, '0, '0);
    add_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'd200, 1'b0, 1'b0);
    add_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'd210, 1'b0, 1'b0);
    add_sample(32'd5, 32'd5, 32'd220, 1'b0, 1'b0);
    add_sample(32'hFFFF_FFFF, 32'h0, 32'd230, 1'b0, 1'b0);
    add_sample(32'h1234_5678, 32'h0, 32'd240, 1'b1, 1'b1);
    add_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'd250, 1'b0, 1'b1);
    wait_idle();

    // Largest range, threshold and limit.
    apply_settings(1'b1, '1, '1, '1);
    add_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'd300, 1'b0, 1'b0);
    add_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'd310, 1'b0, 1'b0);
    add_sample(32'h0, 32'h8000_0000, 32'd320, 1'b0, 1'b0);
    wait_idle();

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      en_v = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 5))
        0:       span_v = '0;
        1:       span_v = 1;
        2:       span_v = RANGE_W'(FULL_TURN_DEG);
        3:       span_v = RANGE_W'(FULL_TURN_RAD);
        4:       span_v = RANGE_W'($urandom_range(0, 32'h7FFF_FFFF));
        default: span_v = '1;
      endcase
      case (ph)
        0: begin
          en_v   = 1'b1;
          span_v = 1;
        end
        1: begin
          en_v   = 1'b0;
          span_v = RANGE_W'(FULL_TURN_DEG);
        end
        2: begin
          en_v   = 1'b1;
          span_v = '0;
        end
        default: ;
      endcase
      case ($urandom_range(0, 4))
        0:       thr_v = '0;
        1:       thr_v = THR_W'($urandom_range(0, 20 * DEG));
        2:       thr_v = span_v >> 3;
        3:       thr_v = THR_W'($urandom_range(0, 32'h7FFF_FFFF));
        default: thr_v = '1;
      endcase
      case ($urandom_range(0, 3))
        0:       lim_v = '0;
        1:       lim_v = $urandom_range(1, 3000);
        2:       lim_v = $urandom;
        default: lim_v = '1;
      endcase
      steady = (ph == 3);
      apply_settings(en_v, span_v, thr_v, lim_v);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        // Runs of samples on one side of the threshold let the timer mature.
        if ($urandom_range(0, 15) == 0) hold_over = !hold_over;
        clock_cursor += (roll < 4) ? $urandom : $urandom_range(0, 600);
        s.now     = clock_cursor;
        s.ref_v   = $urandom;
        s.est_v   = $urandom;
        s.safety  = 1'b0;
        s.invalid = 1'b0;
        if (roll < 3) begin
          s.safety  = 1'b1;
          s.invalid = $urandom_range(0, 1);
        end else if (roll < 6) begin
          s.invalid = 1'b1;
        end else if (roll >= 14) begin
          // Well-formed sample: error placed around the threshold.
          if (hold_over) begin
            mag = longint'(err_thr_q) + 1 + $urandom_range(0, 4096);
          end else begin
            mag = $urandom_range(0, err_thr_q);
          end
          if (mag > VAL_MAX) mag = VAL_MAX;
          if ($urandom_range(0, 1) != 0) mag = -mag;
          if (wrap_en_q && wrap_range_q != 0 && $urandom_range(0, 3) == 0) begin
            mag = ($urandom_range(0, 1) != 0) ? mag + wrap_range_q : mag - wrap_range_q;
          end
          s.ref_v = s.est_v + mag[VW-1:0];
        end
        sample_backlog.push_back(s);
      end
      wait_idle();
    end

    steady = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
